// ===== rtl/core/caip_pkg.sv =====
// ----------------------------------------------------------------------------
// caip_pkg: shared types, constants and fixed-point helpers
// Payload structs, configuration record, item classes and the saturating
// Q-format arithmetic used by the front, the back and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package caip_pkg;

  // screen geometry and fixed-point format
  localparam int PIXELS_X      = 1024;
  localparam int PIXELS_Y      = 614;
  localparam int MID_X         = 512;
  localparam int MID_Y         = 307;
  localparam int FRACTION_BITS = 16;

  // dividend width of the divider, large enough for the screen constants
  localparam int DIV_AW    = 40;
  // quotient bits resolved one per stage (bits 32 down to 0)
  localparam int DIV_STEPS = 33;
  // entry, init, bit stages and output register
  localparam int DIV_LAT   = DIV_STEPS + 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  localparam logic signed [63:0] QONE    = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] QMASK   = QONE - 64'sd1;
  localparam logic signed [63:0] HALF_Q  = QONE / 2;
  localparam logic signed [63:0] NINE_Q  = QONE * 9;
  localparam logic signed [63:0] TEN_Q   = QONE * 10;
  localparam logic signed [63:0] WQ      = QONE * PIXELS_X;
  localparam logic signed [63:0] HQ      = QONE * PIXELS_Y;
  localparam logic signed [63:0] HALF_WQ = WQ / 2;
  localparam logic signed [63:0] HALF_HQ = HQ / 2;
  localparam logic signed [63:0] CX_Q    = QONE * MID_X;
  localparam logic signed [63:0] CY_Q    = QONE * MID_Y;

  // projection modes
  localparam logic [1:0] MODE_FLAT  = 2'd1;
  localparam logic [1:0] MODE_PERSP = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_CAM_X    = 3'd1;
  localparam logic [2:0] REG_CAM_Y    = 3'd2;
  localparam logic [2:0] REG_CAM_Z    = 3'd3;
  localparam logic [2:0] REG_REF_DIST = 3'd4;
  localparam logic [2:0] REG_SPAN_X   = 3'd5;
  localparam logic [2:0] REG_SPAN_Y   = 3'd6;
  localparam logic [2:0] REG_RISE     = 3'd7;

  // reset values of the registers
  localparam logic signed [31:0] RST_CAM_Y  = 32'(QONE * 3);
  localparam logic [30:0]        RST_REF    = 31'(QONE * 10);
  localparam logic signed [31:0] RST_SPAN_X = 32'(QONE * 10);
  localparam logic signed [31:0] RST_SPAN_Y = 32'(QONE * 6);
  localparam logic signed [31:0] RST_RISE   = 32'(QONE * 24);

  typedef enum logic [1:0] {
    KIND_REJECT,
    KIND_FLAT,
    KIND_PERSP
  } kind_e;

  typedef struct packed {
    logic signed [31:0] item_x;
    logic signed [31:0] item_y;
    logic signed [31:0] item_z;
    logic signed [31:0] plane_depth;
    logic signed [31:0] item_lift;
    logic signed [31:0] item_scale_x;
    logic signed [31:0] item_scale_y;
  } item_t;

  typedef struct packed {
    logic               visible;
    logic [7:0]         opacity;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] drawn_scale_x;
    logic signed [31:0] drawn_scale_y;
  } result_t;

  typedef struct packed {
    logic [1:0]         projection_mode;
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
    logic [30:0]        reference_distance;
    logic signed [31:0] view_span_x;
    logic signed [31:0] view_span_y;
    logic signed [31:0] camera_rise;
  } cfg_t;

  // classified item as queued between front and back
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         alpha;
    logic signed [31:0] dz;
    logic signed [31:0] dxs;
    logic signed [31:0] dys;
    logic signed [31:0] plane;
    logic signed [31:0] lift;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } front_t;

  // clamp a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = S32_MAX;
    end else if (v < -64'sd2147483648) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // finish a Q product: drop fraction toward zero, then saturate
  function automatic logic signed [31:0] qmul_fin(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = p + (p[63] ? QMASK : 64'sd0);
    r = r >>> FRACTION_BITS;
    return sat64(r);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/caip_item_if.sv =====
// ----------------------------------------------------------------------------
// caip_item_if: placed item channel
// Valid/ready channel carrying one placed item request.
// ----------------------------------------------------------------------------
`default_nettype none

interface caip_item_if;
  import caip_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/caip_result_if.sv =====
// ----------------------------------------------------------------------------
// caip_result_if: projection result channel
// Valid/ready channel carrying one projected result request.
// ----------------------------------------------------------------------------
`default_nettype none

interface caip_result_if;
  import caip_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/camera_item_projection.sv =====
// ----------------------------------------------------------------------------
// camera_item_projection: camera projection of placed items
// Configuration registers, the queue between intake and projection
// pipeline, and the two halves of the block.
// ----------------------------------------------------------------------------
// Usage:
//  item_i carries placed item requests, result_o the projected results, both
//  valid/ready; a request moves on an edge where valid and ready are high.
//  Camera and mode registers are written through cfg_we_i/cfg_idx_i/
//  cfg_wdata_i; the user must write them only while no item is in flight,
//  which the block itself does not enforce. One item is accepted per cycle
//  while the queue has room and one result leaves per cycle while result_o
//  is ready. From acceptance the queue hands the item on into the entry
//  stage, then two chained 36-stage divider phases (one quotient bit per bit
//  stage) and four multiply and output stages carry it to the result.
//  When result_o stalls the whole projection pipeline holds; the four-entry
//  queue keeps taking items until it fills, then item_i.ready drops.
//  Reset empties the queue and pipeline and loads the default camera:
//  flat zoom mode, height 3, reference depth 10, spans 10 by 6, rise 24.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_item_projection (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  caip_item_if.sink   item_i,
  caip_result_if.source result_o
);
  import caip_pkg::*;

  cfg_t   cfg_q;
  logic   push, pop, full, head_valid;
  front_t entry;
  front_t fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.projection_mode    <= MODE_FLAT;
      cfg_q.camera_x           <= 32'sd0;
      cfg_q.camera_y           <= RST_CAM_Y;
      cfg_q.camera_z           <= 32'sd0;
      cfg_q.reference_distance <= RST_REF;
      cfg_q.view_span_x        <= RST_SPAN_X;
      cfg_q.view_span_y        <= RST_SPAN_Y;
      cfg_q.camera_rise        <= RST_RISE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:     cfg_q.projection_mode    <= cfg_wdata_i[1:0];
        REG_CAM_X:    cfg_q.camera_x           <= cfg_wdata_i;
        REG_CAM_Y:    cfg_q.camera_y           <= cfg_wdata_i;
        REG_CAM_Z:    cfg_q.camera_z           <= cfg_wdata_i;
        REG_REF_DIST: cfg_q.reference_distance <= cfg_wdata_i[30:0];
        REG_SPAN_X:   cfg_q.view_span_x        <= cfg_wdata_i;
        REG_SPAN_Y:   cfg_q.view_span_y        <= cfg_wdata_i;
        REG_RISE:     cfg_q.camera_rise        <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  caip_front u_front (
    .cfg_i   (cfg_q),
    .item_i  (item_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  // queue between intake and projection
  assign full       = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid = (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

  caip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (fifo_q[rd_ptr_q]),
    .pop_o        (pop),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/caip_front.sv =====
// ----------------------------------------------------------------------------
// caip_front: item intake and classification
// Takes a placed item, forms the camera-relative offsets, picks the
// projection path and works out the fade value before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module caip_front (
  input  caip_pkg::cfg_t   cfg_i,
  caip_item_if.sink        item_i,
  input  logic             full_i,
  output logic             push_o,
  output caip_pkg::front_t entry_o
);
  import caip_pkg::*;

  logic signed [31:0] dz;
  logic signed [63:0] dz64;

  // handshake: take requests while the queue has room
  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  // camera-relative offsets
  assign dz   = sat64(64'(item_i.data.item_z) - 64'(cfg_i.camera_z));
  assign dz64 = 64'(dz);

  // classification and fade
  always_comb begin
    entry_o.dz    = dz;
    entry_o.dxs   = sat64(64'(item_i.data.item_x) - 64'(cfg_i.camera_x));
    entry_o.dys   = sat64(64'(cfg_i.camera_y) - 64'(item_i.data.item_y));
    entry_o.plane = item_i.data.plane_depth;
    entry_o.lift  = item_i.data.item_lift;
    entry_o.sx    = item_i.data.item_scale_x;
    entry_o.sy    = item_i.data.item_scale_y;
    entry_o.kind  = KIND_REJECT;
    entry_o.alpha = 8'd0;
    case (cfg_i.projection_mode)
      MODE_FLAT: begin
        if (dz64 > 64'sd0 && cfg_i.view_span_x != 32'sd0 && cfg_i.view_span_y != 32'sd0) begin
          entry_o.kind = KIND_FLAT;
        end
        // ramp over the last half unit before the camera
        if (dz64 < HALF_Q) begin
          entry_o.alpha = 8'((dz64 * 64'sd512) >>> FRACTION_BITS);
        end else begin
          entry_o.alpha = 8'd255;
        end
      end
      MODE_PERSP: begin
        if (dz64 > NINE_Q) begin
          entry_o.kind = KIND_PERSP;
        end
        // ramp over the unit past the cull distance
        if (dz64 >= TEN_Q) begin
          entry_o.alpha = 8'd255;
        end else begin
          entry_o.alpha = 8'(((dz64 - NINE_Q) * 64'sd256) >>> FRACTION_BITS);
        end
      end
      default: begin
        entry_o.kind = KIND_REJECT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/caip_div.sv =====
// ----------------------------------------------------------------------------
// caip_div: pipelined saturating Q divider
// Computes (a << FRACTION_BITS) / b truncated toward zero and clamped to
// 32 bits, one quotient bit per stage, advancing when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module caip_div (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [caip_pkg::DIV_AW-1:0]    a_i,
  input  logic signed [31:0]                    b_i,
  output logic signed [31:0]                    q_o
);
  import caip_pkg::*;

  localparam int NW   = DIV_AW + FRACTION_BITS;
  localparam int HI_W = NW - DIV_STEPS;

  typedef struct packed {
    logic [31:0]          rem;
    logic [DIV_STEPS-1:0] low;
    logic [DIV_STEPS-1:0] quo;
    logic [31:0]          d;
    logic                 ovf;
    logic                 neg;
    logic                 bz;
    logic                 apos;
    logic                 aneg;
  } stage_t;

  logic [DIV_AW-1:0] ea_mag_q;
  logic [31:0]       eb_mag_q;
  logic              e_neg_q, e_bz_q, e_apos_q, e_aneg_q;
  logic [NW-1:0]     num;
  logic [HI_W-1:0]   hi;
  stage_t            init;
  stage_t            stg_q [DIV_STEPS+1];
  stage_t            last;
  logic signed [31:0] q_d;
  logic signed [31:0] q_q;

  // one restoring step: bring in the next dividend bit
  function automatic stage_t div_step(input stage_t s);
    stage_t      r;
    logic [32:0] trial;
    r     = s;
    trial = {s.rem, s.low[DIV_STEPS-1]};
    r.low = {s.low[DIV_STEPS-2:0], 1'b0};
    if (trial >= {1'b0, s.d}) begin
      r.rem = 32'(trial - {1'b0, s.d});
      r.quo = {s.quo[DIV_STEPS-2:0], 1'b1};
    end else begin
      r.rem = trial[31:0];
      r.quo = {s.quo[DIV_STEPS-2:0], 1'b0};
    end
    return r;
  endfunction

  // operand magnitudes and sign handling
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ea_mag_q <= a_i[DIV_AW-1] ? DIV_AW'(-a_i) : DIV_AW'(a_i);
      eb_mag_q <= b_i[31] ? 32'(-b_i) : 32'(b_i);
      e_neg_q  <= a_i[DIV_AW-1] ^ b_i[31];
      e_bz_q   <= (b_i == 32'sd0);
      e_apos_q <= !a_i[DIV_AW-1] && (a_i != '0);
      e_aneg_q <= a_i[DIV_AW-1];
    end
  end

  // overflow test on the bits above the quotient window
  always_comb begin
    num       = {ea_mag_q, {FRACTION_BITS{1'b0}}};
    hi        = num[NW-1:DIV_STEPS];
    init.rem  = 32'(hi);
    init.low  = num[DIV_STEPS-1:0];
    init.quo  = '0;
    init.d    = eb_mag_q;
    init.ovf  = (33'(hi) >= {1'b0, eb_mag_q});
    init.neg  = e_neg_q;
    init.bz   = e_bz_q;
    init.apos = e_apos_q;
    init.aneg = e_aneg_q;
  end

  // bit stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= init;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        stg_q[k] <= div_step(stg_q[k-1]);
      end
    end
  end

  // sign and saturation of the quotient
  assign last = stg_q[DIV_STEPS];
  always_comb begin
    if (last.bz) begin
      q_d = last.apos ? S32_MAX : (last.aneg ? S32_MIN : 32'sd0);
    end else if (!last.neg) begin
      q_d = (last.ovf || last.quo > 33'h07fffffff) ? S32_MAX : last.quo[31:0];
    end else begin
      q_d = (last.ovf || last.quo > 33'h080000000) ? S32_MIN : 32'(-last.quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// ===== rtl/core/caip_back.sv =====
// ----------------------------------------------------------------------------
// caip_back: projection pipeline
// Pulls classified items from the queue and carries out the two divider
// phases, the multiply chain and the final offsets into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module caip_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  caip_pkg::cfg_t   cfg_i,
  input  logic             head_valid_i,
  input  caip_pkg::front_t head_i,
  output logic             pop_o,
  caip_result_if.source    result_o
);
  import caip_pkg::*;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         alpha;
    logic signed [31:0] dxs;
    logic signed [31:0] dys;
    logic signed [31:0] lift;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] diff;
    logic               tneg;
    logic signed [31:0] scale_pos;
  } ctx_a_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         alpha;
    logic signed [31:0] dxs;
    logic signed [31:0] dys;
    logic signed [31:0] lift;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] diff;
    logic signed [31:0] scale;
    logic signed [31:0] unit;
    logic signed [31:0] across;
    logic signed [31:0] down;
  } ctx_b_t;

  logic en;

  // entry stage
  logic               v0_q;
  front_t             e0_q;
  logic signed [31:0] diff0_q;
  logic signed [63:0] pvx0_q, pvy0_q;

  // divider phase a
  logic signed [31:0]       t1;
  ctx_a_t                   ctx_a;
  logic signed [DIV_AW-1:0] da_a [4];
  logic signed [31:0]       da_b [4];
  logic signed [31:0]       qa   [4];
  ctx_a_t                   dla_q [DIV_LAT];
  logic [DIV_LAT-1:0]       vla_q;

  // divider phase b
  ctx_a_t             ca;
  ctx_b_t             ctx_b;
  logic signed [31:0] qb [2];
  ctx_b_t             dlb_q [DIV_LAT];
  logic [DIV_LAT-1:0] vlb_q;
  ctx_b_t             cb;

  // multiply chain
  logic               v1_q, v2_q, v3_q;
  logic               flat1_q, flat2_q;
  logic               ok1_q, ok2_q, ok3_q;
  logic [7:0]         al1_q, al2_q, al3_q;
  logic signed [31:0] lift1_q, scale1_q, q2x1_q, y21_q;
  logic signed [63:0] px1_q, py1_q, pdsx1_q, pdsy1_q, pr1_q;
  logic signed [31:0] dsx2_q, dsy2_q, r2_q;
  logic signed [63:0] px2_q, py2_q, pdsx2_q, pdsy2_q;
  logic signed [31:0] x3_q, yb3_q, dsx3_q, dsy3_q, r3_q;
  logic signed [31:0] x1, ya, dsx1, dsy1;

  // output register
  logic    out_valid_q;
  result_t out_q;

  assign en    = !out_valid_q || result_o.ready;
  assign pop_o = en && head_valid_i;

  // entry stage: plane offset and view span products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_q    <= head_i;
      diff0_q <= sat64(64'(head_i.plane) - 64'(head_i.dz));
      pvx0_q  <= 64'(cfg_i.view_span_x) * 64'(head_i.dz);
      pvy0_q  <= 64'(cfg_i.view_span_y) * 64'(head_i.dz);
    end
  end

  // phase a operands per projection path
  assign t1 = 32'((64'(diff0_q) + (diff0_q[31] ? 64'sd1 : 64'sd0)) >>> 1);

  always_comb begin
    ctx_a.kind      = e0_q.kind;
    ctx_a.alpha     = e0_q.alpha;
    ctx_a.dxs       = e0_q.dxs;
    ctx_a.dys       = e0_q.dys;
    ctx_a.lift      = e0_q.lift;
    ctx_a.sx        = e0_q.sx;
    ctx_a.sy        = e0_q.sy;
    ctx_a.diff      = diff0_q;
    ctx_a.tneg      = t1[31];
    ctx_a.scale_pos = sat64(QONE + 64'(t1));
    da_a[1] = DIV_AW'(cfg_i.reference_distance);
    da_b[1] = e0_q.dz;
    if (e0_q.kind == KIND_PERSP) begin
      da_a[0] = DIV_AW'(e0_q.plane);
      da_b[0] = e0_q.dz;
      da_a[2] = DIV_AW'(qmul_fin(pvx0_q));
      da_b[2] = 32'(cfg_i.reference_distance);
      da_a[3] = DIV_AW'(qmul_fin(pvy0_q));
      da_b[3] = 32'(cfg_i.reference_distance);
    end else begin
      da_a[0] = DIV_AW'(QONE);
      da_b[0] = sat64(QONE - 64'(t1));
      da_a[2] = DIV_AW'(WQ);
      da_b[2] = cfg_i.view_span_x;
      da_a[3] = DIV_AW'(HQ);
      da_b[3] = cfg_i.view_span_y;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div_a
    caip_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (da_a[g]),
      .b_i   (da_b[g]),
      .q_o   (qa[g])
    );
  end

  // context alongside phases a and b
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vla_q <= '0;
      vlb_q <= '0;
    end else if (en) begin
      vla_q <= {vla_q[DIV_LAT-2:0], v0_q};
      vlb_q <= {vlb_q[DIV_LAT-2:0], vla_q[DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dla_q[0] <= ctx_a;
      dlb_q[0] <= ctx_b;
      for (int k = 1; k < DIV_LAT; k++) begin
        dla_q[k] <= dla_q[k-1];
        dlb_q[k] <= dlb_q[k-1];
      end
    end
  end

  // phase a results: pick the scale
  assign ca = dla_q[DIV_LAT-1];
  always_comb begin
    ctx_b.kind   = ca.kind;
    ctx_b.alpha  = ca.alpha;
    ctx_b.dxs    = ca.dxs;
    ctx_b.dys    = ca.dys;
    ctx_b.lift   = ca.lift;
    ctx_b.sx     = ca.sx;
    ctx_b.sy     = ca.sy;
    ctx_b.diff   = ca.diff;
    ctx_b.scale  = (ca.kind == KIND_FLAT && !ca.tneg) ? ca.scale_pos : qa[0];
    ctx_b.unit   = qa[1];
    ctx_b.across = qa[2];
    ctx_b.down   = qa[3];
  end

  // phase b: pixels per world unit for the perspective path
  caip_div u_div_kx (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (DIV_AW'(WQ)),
    .b_i   (qa[2]),
    .q_o   (qb[0])
  );

  caip_div u_div_ky (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (DIV_AW'(HQ)),
    .b_i   (qa[3]),
    .q_o   (qb[1])
  );

  assign cb = dlb_q[DIV_LAT-1];

  // first products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= vlb_q[DIV_LAT-1];
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flat1_q  <= (cb.kind == KIND_FLAT);
      ok1_q    <= (cb.kind == KIND_FLAT) ||
                  (cb.kind == KIND_PERSP && cb.across != 32'sd0 && cb.down != 32'sd0);
      al1_q    <= cb.alpha;
      lift1_q  <= cb.lift;
      scale1_q <= cb.scale;
      pdsx1_q  <= 64'(cb.sx) * 64'(cb.scale);
      pdsy1_q  <= 64'(cb.sy) * 64'(cb.scale);
      pr1_q    <= 64'(cb.diff) * 64'(cfg_i.camera_rise);
      if (cb.kind == KIND_FLAT) begin
        px1_q  <= 64'(cb.dxs) * 64'(cb.unit);
        py1_q  <= 64'(cb.dys) * 64'(cb.unit);
        q2x1_q <= cb.across;
        y21_q  <= cb.down;
      end else begin
        px1_q  <= 64'(qb[0]) * 64'(cb.scale);
        py1_q  <= 64'(cb.scale) * 64'(cb.dys);
        q2x1_q <= cb.dxs;
        y21_q  <= qb[1];
      end
    end
  end

  // second products
  assign x1   = qmul_fin(px1_q);
  assign ya   = sat64(64'(qmul_fin(py1_q)) + 64'(lift1_q));
  assign dsx1 = qmul_fin(pdsx1_q);
  assign dsy1 = qmul_fin(pdsy1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      flat2_q <= flat1_q;
      ok2_q   <= ok1_q;
      al2_q   <= al1_q;
      dsx2_q  <= dsx1;
      dsy2_q  <= dsy1;
      r2_q    <= qmul_fin(pr1_q);
      px2_q   <= 64'(x1) * 64'(q2x1_q);
      py2_q   <= 64'(ya) * 64'(y21_q);
      pdsx2_q <= 64'(dsx1) * 64'(scale1_q);
      pdsy2_q <= 64'(dsy1) * 64'(scale1_q);
    end
  end

  // screen offsets and final scales
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok3_q   <= ok2_q;
      al3_q   <= al2_q;
      r3_q    <= r2_q;
      x3_q    <= sat64(64'(qmul_fin(px2_q)) + (flat2_q ? HALF_WQ : CX_Q));
      yb3_q   <= sat64(64'(qmul_fin(py2_q)) + (flat2_q ? HALF_HQ : CY_Q));
      dsx3_q  <= flat2_q ? dsx2_q : qmul_fin(pdsx2_q);
      dsy3_q  <= flat2_q ? dsy2_q : qmul_fin(pdsy2_q);
    end
  end

  // output register, zeroed for rejected items
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ok3_q) begin
        out_q.visible       <= 1'b1;
        out_q.opacity       <= al3_q;
        out_q.screen_x      <= x3_q;
        out_q.screen_y      <= sat64(64'(yb3_q) + 64'(r3_q));
        out_q.drawn_scale_x <= dsx3_q;
        out_q.drawn_scale_y <= dsy3_q;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: camera item projection testbench
// Drives placed items through several camera settings in flat zoom and
// perspective modes, predicts each projected result in fixed point and
// compares it field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import caip_pkg::*;

  localparam int LATENCY = 78;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint QU = 64'sd65536;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  caip_item_if   item_ch ();
  caip_result_if result_ch ();

  camera_item_projection u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_ch.sink),
    .result_o   (result_ch.source)
  );

  // camera copy used for prediction
  cfg_t    cam;
  item_t   pending_items[$];
  result_t expected_results[$];
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      hold_send;
  bit      failed;
  int      quiet_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // saturating fixed-point helpers
  function automatic longint clip(input longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  function automatic longint fmul(input longint a, input longint b);
    return clip((a * b) / QU);
  endfunction

  function automatic longint fdiv(input longint a, input longint b);
    if (b == 0) return (a > 0) ? MAXV : ((a < 0) ? MINV : 0);
    return clip((a * QU) / b);
  endfunction

  function automatic result_t project_item(input item_t it);
    result_t r;
    longint ix, iy, plane, lift, sx, sy, dz, diff, t, scale, alpha;
    longint unit, across, down, kx, ky, x, y, wq, hq;
    bit ok;
    ix = it.item_x; iy = it.item_y; plane = it.plane_depth;
    lift = it.item_lift; sx = it.item_scale_x; sy = it.item_scale_y;
    wq = 1024 * QU; hq = 614 * QU;
    r = '0;
    ok = 1'b0;
    alpha = 0;
    dz = clip(longint'(it.item_z) - longint'(cam.camera_z));
    diff = clip(plane - dz);
    if (cam.projection_mode == MODE_FLAT) begin
      if (dz > 0 && cam.view_span_x != 0 && cam.view_span_y != 0) begin
        t = diff / 2;
        scale = (t >= 0) ? clip(QU + t) : fdiv(QU, QU - t);
        alpha = (dz < QU / 2) ? (dz * 512) / QU : 255;
        unit = fdiv(longint'(cam.reference_distance), dz);
        across = fdiv(wq, cam.view_span_x);
        down = fdiv(hq, cam.view_span_y);
        x = clip(fmul(fmul(clip(ix - cam.camera_x), unit), across) + wq / 2);
        y = fmul(clip(fmul(clip(longint'(cam.camera_y) - iy), unit) + lift), down);
        y = clip(clip(y + hq / 2) + fmul(diff, cam.camera_rise));
        r.drawn_scale_x = 32'(fmul(sx, scale));
        r.drawn_scale_y = 32'(fmul(sy, scale));
        ok = 1'b1;
      end
    end else if (cam.projection_mode == MODE_PERSP) begin
      if (dz > 9 * QU) begin
        scale = fdiv(plane, dz);
        alpha = (dz >= 10 * QU) ? 255 : ((dz - 9 * QU) * 256) / QU;
        across = fdiv(fmul(cam.view_span_x, dz), longint'(cam.reference_distance));
        down = fdiv(fmul(cam.view_span_y, dz), longint'(cam.reference_distance));
        if (across != 0 && down != 0) begin
          kx = fdiv(wq, across);
          ky = fdiv(hq, down);
          x = clip(fmul(fmul(kx, scale), clip(ix - cam.camera_x)) + 512 * QU);
          y = fmul(ky, clip(fmul(scale, clip(longint'(cam.camera_y) - iy)) + lift));
          y = clip(clip(y + 307 * QU) + fmul(diff, cam.camera_rise));
          r.drawn_scale_x = 32'(fmul(fmul(sx, scale), scale));
          r.drawn_scale_y = 32'(fmul(fmul(sy, scale), scale));
          ok = 1'b1;
        end
      end
    end
    if (ok) begin
      r.visible = 1'b1;
      r.opacity = (alpha < 0) ? 8'd0 : ((alpha > 255) ? 8'd255 : 8'(alpha));
      r.screen_x = 32'(x);
      r.screen_y = 32'(y);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // driver: one request per handshake, random gaps; while holding, the
  // sender waits until every outstanding result has come back
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_ch.valid <= 1'b0;
      item_ch.data  <= '0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        expected_results.push_back(project_item(item_ch.data));
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (pending_items.size() > 0 &&
            !(hold_send && expected_results.size() > 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          item_ch.valid <= 1'b1;
          item_ch.data  <= pending_items.pop_front();
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    result_t got;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      quiet_cycles    <= 0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (expected_results.size() == 0) begin
          $error("unexpected result request");
          failed = 1'b1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.visible !== exp_r.visible) begin
            $error("visible: expected %0d, got %0d", exp_r.visible, got.visible);
            failed = 1'b1;
          end
          if (got.opacity !== exp_r.opacity) begin
            $error("opacity: expected %0d, got %0d", exp_r.opacity, got.opacity);
            failed = 1'b1;
          end
          if (got.screen_x !== exp_r.screen_x) begin
            $error("screen_x: expected %0d, got %0d", exp_r.screen_x, got.screen_x);
            failed = 1'b1;
          end
          if (got.screen_y !== exp_r.screen_y) begin
            $error("screen_y: expected %0d, got %0d", exp_r.screen_y, got.screen_y);
            failed = 1'b1;
          end
          if (got.drawn_scale_x !== exp_r.drawn_scale_x) begin
            $error("drawn_scale_x: expected %0d, got %0d",
                   exp_r.drawn_scale_x, got.drawn_scale_x);
            failed = 1'b1;
          end
          if (got.drawn_scale_y !== exp_r.drawn_scale_y) begin
            $error("drawn_scale_y: expected %0d, got %0d",
                   exp_r.drawn_scale_y, got.drawn_scale_y);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // watchdog on handshakes on either channel
  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // wait until the pipeline has drained
  task automatic wait_drained();
    while (pending_items.size() > 0 || item_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:     cam.projection_mode    = val[1:0];
      REG_CAM_X:    cam.camera_x           = val;
      REG_CAM_Y:    cam.camera_y           = val;
      REG_CAM_Z:    cam.camera_z           = val;
      REG_REF_DIST: cam.reference_distance = val[30:0];
      REG_SPAN_X:   cam.view_span_x        = val;
      REG_SPAN_Y:   cam.view_span_y        = val;
      default:      cam.camera_rise        = val;
    endcase
  endtask

  // mostly modest values near the camera, sometimes a raw 32-bit word
  function automatic logic [31:0] pick_value(input int span_units);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom;
    if (sel == 1) return {$urandom_range(1) ? 32'hffffffff : 32'h0};
    return 32'($signed($urandom_range(2 * span_units * 65536)) - span_units * 65536);
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.item_x       = pick_value(40);
    it.item_y       = pick_value(20);
    it.item_z       = 32'(cam.camera_z) + pick_value(30);
    it.plane_depth  = pick_value(30);
    it.item_lift    = pick_value(10);
    it.item_scale_x = pick_value(4);
    it.item_scale_y = pick_value(4);
    if ($urandom_range(7) == 0) it.item_z = $urandom;
    return it;
  endfunction

  function automatic item_t make_item(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [31:0] p,
                                      input logic [31:0] l, input logic [31:0] sx,
                                      input logic [31:0] sy);
    item_t it;
    it.item_x = x; it.item_y = y; it.item_z = z; it.plane_depth = p;
    it.item_lift = l; it.item_scale_x = sx; it.item_scale_y = sy;
    return it;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) pending_items.push_back(random_item());
    wait_drained();
  endtask

  task automatic set_camera(input logic [1:0] mode, input logic [31:0] cz,
                            input logic [31:0] rd, input logic [31:0] spx,
                            input logic [31:0] spy);
    repeat (LATENCY + 4) @(posedge clk_i);
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_CAM_X, pick_value(20));
    write_reg(REG_CAM_Y, pick_value(10));
    write_reg(REG_CAM_Z, cz);
    write_reg(REG_REF_DIST, rd);
    write_reg(REG_SPAN_X, spx);
    write_reg(REG_SPAN_Y, spy);
    write_reg(REG_RISE, pick_value(40));
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    failed        = 1'b0;
    hold_send     = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 83;
    cam.projection_mode    = MODE_FLAT;
    cam.camera_x           = '0;
    cam.camera_y           = RST_CAM_Y;
    cam.camera_z           = '0;
    cam.reference_distance = RST_REF;
    cam.view_span_x        = RST_SPAN_X;
    cam.view_span_y        = RST_SPAN_Y;
    cam.camera_rise        = RST_RISE;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset camera, flat zoom edges (fade, behind camera, t signs)
    pending_items.push_back(make_item(0, 0, 32'h8000, 0, 0, 32'h10000, 32'h10000));
    pending_items.push_back(make_item(0, 0, 32'h4000, 0, 0, 32'h10000, 32'h10000));
    pending_items.push_back(make_item(0, 0, 0, 0, 0, 32'h10000, 32'h10000));
    pending_items.push_back(make_item(0, 0, 32'hffff0000, 0, 0, 1, 1));
    pending_items.push_back(make_item(32'h50000, 32'h10000, 32'ha0000, 32'h140000,
                                      32'h8000, 32'h20000, 32'h18000));
    pending_items.push_back(make_item(32'h50000, 32'h10000, 32'ha0000, 32'hfff00000,
                                      32'h8000, 32'h20000, 32'h18000));
    pending_items.push_back(make_item(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                      32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                      32'h80000000));
    pending_items.push_back(make_item(32'h80000000, 32'h7fffffff, 1, 32'h7fffffff,
                                      32'h80000000, 32'h80000000, 32'h7fffffff));
    pending_items.push_back(make_item(32'hffffffff, 32'hffffffff, 32'hffffffff,
                                      32'hffffffff, 32'hffffffff, 32'hffffffff,
                                      32'hffffffff));
    wait_drained();

    // perspective: cull at nine units, fade to ten, zero reference distance and span
    repeat (LATENCY + 4) @(posedge clk_i);
    write_reg(REG_MODE, {30'd0, MODE_PERSP});
    pending_items.push_back(make_item(0, 0, 32'h90000, 32'ha0000, 0, 32'h10000, 32'h10000));
    pending_items.push_back(make_item(0, 0, 32'h90001, 32'ha0000, 0, 32'h10000, 32'h10000));
    pending_items.push_back(make_item(0, 0, 32'h98000, 32'ha0000, 0, 32'h10000, 32'h10000));
    pending_items.push_back(make_item(32'h30000, 32'h10000, 32'ha0000, 32'h140000,
                                      32'h10000, 32'h20000, 32'h10000));
    pending_items.push_back(make_item(0, 0, 32'h7fffffff, 32'h80000000, 0,
                                      32'h7fffffff, 32'h80000000));
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk_i);
    write_reg(REG_REF_DIST, 32'h0);
    pending_items.push_back(make_item(0, 0, 32'h140000, 32'h140000, 0, 32'h10000, 32'h10000));
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk_i);
    write_reg(REG_REF_DIST, 32'h7fffffff);
    write_reg(REG_SPAN_X, 32'h0);
    pending_items.push_back(make_item(0, 0, 32'h140000, 32'h140000, 0, 32'h10000, 32'h10000));
    wait_drained();

    // rejecting modes
    for (int m = 0; m < 4; m += 2) begin
      repeat (LATENCY + 4) @(posedge clk_i);
      write_reg(REG_MODE, 32'(m));
      pending_items.push_back(make_item(0, 0, 32'ha0000, 0, 0, 32'h10000, 32'h10000));
      wait_drained();
    end

    // random phases over a range of camera settings
    set_camera(MODE_FLAT, 0, 32'ha0000, 32'ha0000, 32'h60000);
    run_random(150);
    set_camera(MODE_PERSP, 32'hfffb0000, 32'ha0000, 32'ha0000, 32'h60000);
    run_random(150);
    // sender waits here until every result has come back
    hold_send = 1'b1;
    run_random(10);
    hold_send = 1'b0;
    wait_drained();
    send_idle_pct = 83;
    recv_idle_pct = 29;
    set_camera(MODE_FLAT, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    run_random(120);
    set_camera(MODE_PERSP, 32'h7fffffff, 32'h1, 32'hfff60000, 32'h1);
    run_random(120);
    set_camera(MODE_FLAT, $urandom, $urandom, 32'h0, 32'h40000);
    run_random(60);
    set_camera(MODE_PERSP, 0, 32'h50000, 32'h140000, 32'hfffd0000);
    run_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_camera(MODE_FLAT, pick_value(10), 32'h30000, 32'h80000, 32'h50000);
    run_random(270);
    set_camera(MODE_PERSP, pick_value(10), 32'h140000, 32'h100000, 32'h90000);
    run_random(270);

    repeat (LATENCY + 10) @(posedge clk_i);
    if (!failed && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
